>>> hw/rtl/cej_pkg.sv
// ----------------------------------------------------------------------------
// cej_pkg: shared types, constants and functions
// Constants, codes and the ease curve arithmetic of the cosine eased trajectory
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cej_pkg;

  localparam int unsigned JointCountDefault   = 6;
  localparam int unsigned CurveEntriesDefault = 256;

  localparam int unsigned CfgWidth = 48;

  localparam logic [15:0] AngleReset    = 16'd23040;
  localparam logic [15:0] DurationReset = 16'd300;
  localparam logic [15:0] MinDuration   = 16'd20;
  localparam logic [15:0] HomeDuration  = 16'd1000;

  localparam logic [CfgWidth-1:0] MinReset    = 48'h0;
  localparam logic [CfgWidth-1:0] MaxReset    = 48'hB4B4B4B4B4B4;
  localparam logic [CfgWidth-1:0] CenterReset = 48'h5A5A5A5A5A5A;

  localparam longint unsigned Q30One = 64'd1073741824;
  localparam longint unsigned PiQ30  = 64'd3373259426;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_START = 2'd2,
    MODE_HOME  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MIN    = 2'd0,
    CFG_MAX    = 2'd1,
    CFG_CENTER = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ROM,
    ST_RD,
    ST_CALC,
    ST_WR
  } state_e;

  // one memory word per joint
  typedef struct packed {
    logic [15:0] current;
    logic [15:0] start;
    logic [15:0] target;
    logic [15:0] pending;
  } joint_word_t;

  // whole-degree limit of joint j, zero beyond the packed register
  function automatic logic [7:0] limit_deg(input logic [CfgWidth-1:0] r,
                                           input logic [2:0] j);
    logic [63:0] ext;
    ext = {16'h0, r};
    return ext[{j, 3'b000} +: 8];
  endfunction

  // below min gives min, else above max gives max
  function automatic logic [15:0] clamp_q88(input logic [15:0] v,
                                            input logic [7:0] lo8,
                                            input logic [7:0] hi8);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = {lo8, 8'h00};
    hi = {hi8, 8'h00};
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // ease value in Q1.15 from the Q30 phase x, evaluated at elaboration only
  function automatic logic [15:0] ease_from_x(input longint unsigned x,
                                              input bit mirror);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned p;
    longint unsigned e;
    x2 = (x * x) >> 30;
    t  = Q30One;
    p  = ((x2 * t) >> 30) / 132;
    t  = (p > Q30One) ? 64'd0 : Q30One - p;
    p  = ((x2 * t) >> 30) / 90;
    t  = (p > Q30One) ? 64'd0 : Q30One - p;
    p  = ((x2 * t) >> 30) / 56;
    t  = (p > Q30One) ? 64'd0 : Q30One - p;
    p  = ((x2 * t) >> 30) / 30;
    t  = (p > Q30One) ? 64'd0 : Q30One - p;
    p  = ((x2 * t) >> 30) / 12;
    t  = (p > Q30One) ? 64'd0 : Q30One - p;
    p  = ((x2 * t) >> 30) / 2;
    t  = (p > Q30One) ? 64'd0 : Q30One - p;
    e  = mirror ? Q30One + t : Q30One - t;
    e  = (e + 64'd32768) >> 16;
    return e[15:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cej_if.sv
// ----------------------------------------------------------------------------
// cej item channels
// Valid/ready channels for command items and joint angle result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cej_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  joint;
  logic [15:0] angle;
  logic [15:0] duration_ms;
  logic        motion_allowed;

  modport source (output valid, mode, joint, angle, duration_ms, motion_allowed,
                  input ready);
  modport sink   (input valid, mode, joint, angle, duration_ms, motion_allowed,
                  output ready);
endinterface

interface cej_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  joint_index;
  logic [15:0] joint_angle;
  logic        last_joint;

  modport source (output valid, joint_index, joint_angle, last_joint, input ready);
  modport sink   (input valid, joint_index, joint_angle, last_joint, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cosine_eased_joint_trajectory.sv
// ----------------------------------------------------------------------------
// cosine_eased_joint_trajectory: multi-joint cosine eased trajectory generator
// Per-joint angles live in one synchronous memory; commands read, modify and
// write it back one joint at a time, move ticks emit one eased angle per joint.
// ----------------------------------------------------------------------------
// tick with a move active: the bit-serial index divider runs unless the move ends,
//   then each joint is read, eased and written, waiting for a free result slot
// load: reads and writes one joint; start or home: every joint; others: no access
// after reset a clearing pass sets every joint to 90 degrees
//   while no item is accepted
`default_nettype none

module cosine_eased_joint_trajectory #(
  parameter int unsigned JOINT_COUNT   = cej_pkg::JointCountDefault,
  parameter int unsigned CURVE_ENTRIES = cej_pkg::CurveEntriesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  cej_in_if.sink                            in_if,
  cej_out_if.source                         out_if,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [cej_pkg::CfgWidth-1:0] cfg_data_i
);
  import cej_pkg::*;

  localparam int unsigned JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int unsigned IW = $clog2(CURVE_ENTRIES);
  localparam int unsigned NW = 16 + IW;
  localparam int unsigned N1 = CURVE_ENTRIES - 1;
  localparam logic [JW-1:0] JLast = JW'(JOINT_COUNT - 1);

  // ease curve table
  logic [15:0] ease_rom [CURVE_ENTRIES];
  for (genvar k = 0; k < CURVE_ENTRIES; k++) begin : g_rom
    localparam bit              Mir = (2 * k) > N1;
    localparam longint unsigned Kk  = Mir ? (N1 - k) : k;
    localparam longint unsigned Xq  = PiQ30 * Kk / N1;
    assign ease_rom[k] = ease_from_x(Xq, Mir);
  end

  // configuration registers
  logic [CfgWidth-1:0] min_q, max_q, center_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= MinReset;
      max_q    <= MaxReset;
      center_q <= CenterReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN:    min_q    <= cfg_data_i;
        CFG_MAX:    max_q    <= cfg_data_i;
        CFG_CENTER: center_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  state_e       state_q, state_d;
  mode_e        op_q;
  logic [JW-1:0] j_q;
  logic [15:0]  angle_q;
  logic [15:0]  elapsed_q;
  logic [15:0]  dur_q;
  logic         moving_q;
  logic [IW-1:0] idx_q;
  logic [15:0]  ease_q;
  logic [31:0]  prod_q;
  logic         up_q;
  logic         out_valid_q;
  logic [2:0]   out_joint_q;
  logic [15:0]  out_angle_q;
  logic         out_last_q;

  // joint memory
  joint_word_t  jmem_q [JOINT_COUNT];
  joint_word_t  rdata_q;
  logic         mem_we;
  joint_word_t  mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) jmem_q[j_q] <= mem_wdata;
    if (state_q == ST_RD) rdata_q <= jmem_q[j_q];
  end

  // index divider
  logic          div_start;
  logic          div_done;
  logic [IW-1:0] div_quo;
  logic [NW-1:0] div_num;
  assign div_num = NW'(elapsed_q * NW'(N1));

  cej_div #(.IW(IW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dur_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // per joint datapath
  logic [7:0]  lo8, hi8;
  logic [15:0] goal;
  logic [15:0] diff;
  logic [16:0] mstep;
  logic [15:0] interp;
  logic [15:0] new_angle;
  logic [15:0] el_next;
  logic        out_free;
  mode_e       in_mode;

  assign in_mode  = mode_e'(in_if.mode);
  assign lo8      = limit_deg(min_q, 3'(j_q));
  assign hi8      = limit_deg(max_q, 3'(j_q));
  assign goal     = (op_q == MODE_HOME) ? {limit_deg(center_q, 3'(j_q)), 8'h00}
                                        : rdata_q.pending;
  assign diff     = (rdata_q.target >= rdata_q.start) ? rdata_q.target - rdata_q.start
                                                      : rdata_q.start - rdata_q.target;
  assign mstep    = 17'((prod_q + 32'd16384) >> 15);
  assign interp   = up_q ? 16'(rdata_q.start + mstep[15:0])
                         : 16'(rdata_q.start - mstep[15:0]);
  assign new_angle = clamp_q88(interp, lo8, hi8);
  assign el_next  = elapsed_q + 16'((moving_q && elapsed_q != 16'hFFFF) ? 1 : 0);
  assign out_free = !out_valid_q || out_if.ready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    in_if.ready = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = rdata_q;
    div_start   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '{current: AngleReset, start: AngleReset,
                      target: AngleReset, pending: AngleReset};
        if (j_q == JLast) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          case (in_mode)
            MODE_TICK: begin
              if (in_if.motion_allowed && moving_q) begin
                state_d = (el_next >= dur_q) ? ST_ROM : ST_MUL;
              end
            end
            MODE_LOAD: begin
              if ({1'b0, in_if.joint} < 4'(JOINT_COUNT)) state_d = ST_RD;
            end
            default: begin
              if (in_if.motion_allowed) state_d = ST_RD;
            end
          endcase
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_ROM;
      end
      ST_ROM: state_d = ST_RD;
      ST_RD:  state_d = ST_CALC;
      ST_CALC: begin
        case (op_q)
          MODE_TICK: state_d = ST_WR;
          MODE_LOAD: begin
            mem_we            = 1'b1;
            mem_wdata.pending = angle_q;
            state_d           = ST_IDLE;
          end
          default: begin
            mem_we           = 1'b1;
            mem_wdata.start  = rdata_q.current;
            mem_wdata.target = clamp_q88(goal, lo8, hi8);
            state_d          = (j_q == JLast) ? ST_IDLE : ST_RD;
          end
        endcase
      end
      ST_WR: begin
        if (out_free) begin
          mem_we            = 1'b1;
          mem_wdata.current = new_angle;
          state_d           = (j_q == JLast) ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      j_q         <= '0;
      elapsed_q   <= '0;
      dur_q       <= DurationReset;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= MODE_TICK;
    end else begin
      state_q <= state_d;
      // result register fills on a joint write and drains when taken
      if (state_q == ST_WR && out_free) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: j_q <= (j_q == JLast) ? '0 : j_q + JW'(1);
        ST_IDLE: begin
          if (in_if.valid) begin
            op_q <= in_mode;
            case (in_mode)
              MODE_TICK: begin
                elapsed_q <= el_next;
                j_q       <= '0;
                if (in_if.motion_allowed && moving_q && el_next >= dur_q) begin
                  moving_q <= 1'b0;
                end
              end
              MODE_LOAD: j_q <= JW'(in_if.joint);
              MODE_START: begin
                j_q <= '0;
                if (in_if.motion_allowed) begin
                  dur_q     <= (in_if.duration_ms < MinDuration) ? MinDuration
                                                                 : in_if.duration_ms;
                  elapsed_q <= '0;
                  moving_q  <= 1'b1;
                end
              end
              default: begin
                j_q <= '0;
                if (in_if.motion_allowed) begin
                  dur_q     <= HomeDuration;
                  elapsed_q <= '0;
                  moving_q  <= 1'b1;
                end
              end
            endcase
          end
        end
        ST_CALC: begin
          if (op_q != MODE_TICK && op_q != MODE_LOAD) j_q <= j_q + JW'(1);
        end
        ST_WR: begin
          if (out_free) j_q <= j_q + JW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_if.valid) begin
      angle_q <= in_if.angle;
      idx_q   <= IW'(N1);
    end
    if (state_q == ST_DIV && div_done) idx_q <= div_quo;
    if (state_q == ST_ROM) ease_q <= ease_rom[idx_q];
    if (state_q == ST_CALC) begin
      prod_q <= diff * ease_q;
      up_q   <= rdata_q.target >= rdata_q.start;
    end
    if (state_q == ST_WR && out_free) begin
      out_joint_q <= 3'(j_q);
      out_angle_q <= new_angle;
      out_last_q  <= (j_q == JLast);
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.joint_index = out_joint_q;
  assign out_if.joint_angle = out_angle_q;
  assign out_if.last_joint  = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/cej_div.sv
// ----------------------------------------------------------------------------
// cej_div: restoring divider
// Finds the curve index floor(num/den) one quotient bit a cycle; the quotient
// is known to fit in IW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cej_div #(
  parameter int unsigned IW = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [16+IW-1:0]  num_i,
  input  wire logic [15:0]       den_i,
  output logic                   done_o,
  output logic [IW-1:0]          quo_o
);
  import cej_pkg::*;

  localparam int unsigned NW = 16 + IW;
  localparam int unsigned CW = $clog2(IW + 1);

  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] dsh_q, dsh_d;
  logic [IW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  // one trial subtraction per cycle while busy
  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = NW'({den_i, {(IW-1){1'b0}}});
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_d = rem_q - dsh_q;
        quo_d = {quo_q[IW-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[IW-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(IW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/cej_checker.sv
// ----------------------------------------------------------------------------
// cej_checker: port level checks
// Watches the result channel and the command ready of the trajectory generator over time.
// ----------------------------------------------------------------------------
`default_nettype none

module cej_checker #(
  parameter int unsigned JOINT_COUNT = cej_pkg::JointCountDefault
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_joint,
  input wire logic [15:0] out_angle,
  input wire logic        out_last
);
  import cej_pkg::*;

  // the flagged item is the highest joint
  a_last_joint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_last |-> out_joint == 3'(JOINT_COUNT - 1))
    else $error("last_joint on wrong joint");

  // commands wait while a tick still has joints to send
  a_busy_mid_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready)
    else $error("item accepted in the middle of a tick");

  // joints follow in order within a tick
  a_joint_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=>
      !out_valid || out_joint == 3'($past(out_joint) + 3'd1))
    else $error("joint items out of order");

  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_joint))
    else $error("result item changed while stalled");

endmodule

bind cosine_eased_joint_trajectory cej_checker #(.JOINT_COUNT(JOINT_COUNT)) u_cej_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_joint (out_if.joint_index),
  .out_angle (out_if.joint_angle),
  .out_last  (out_if.last_joint)
);

`default_nettype wire

>>> sim/tb_cosine_eased_joint_trajectory.sv
// ----------------------------------------------------------------------------
// tb_cosine_eased_joint_trajectory: trajectory generator testbench
// Drives load, start, home and tick items with random idling on both channels,
// predicts each joint angle with an independent model of the eased move and
// compares every result item against the oldest expected angle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cosine_eased_joint_trajectory;
  import cej_pkg::*;

  localparam int unsigned Joints   = JointCountDefault;
  localparam int unsigned Curve    = CurveEntriesDefault;
  localparam int unsigned WdLimit  = 20000;

  typedef struct packed {
    logic [2:0]  joint_index;
    logic [15:0] joint_angle;
    logic        last_joint;
  } angle_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CfgWidth-1:0] cfg_data_i;

  cej_in_if  cmd_ch ();
  cej_out_if ang_ch ();

  cosine_eased_joint_trajectory i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (cmd_ch.sink),
    .out_if     (ang_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  logic [CfgWidth-1:0] lim_lo, lim_hi, home_deg;
  logic [15:0] cur_ang [Joints];
  logic [15:0] from_ang [Joints];
  logic [15:0] goal_ang [Joints];
  logic [15:0] queued_ang [Joints];
  logic [15:0] ms_count, move_ms;
  bit          in_motion;
  logic [15:0] ease_rom [Curve];

  angle_res_t  expected_angles [$];
  int          errors;
  int          idle_cycles;
  int          burst_left;

  // ease table built from a truncated cosine series in Q30
  function automatic logic [15:0] calc_ease(input int unsigned idx);
    longint unsigned n1, k, x, x2, t, p, e;
    longint unsigned dv [6];
    bit mir;
    dv = '{132, 90, 56, 30, 12, 2};
    n1 = Curve - 1;
    mir = (2 * idx) > n1;
    k = mir ? n1 - idx : idx;
    x = 64'd3373259426 * k / n1;
    x2 = (x * x) >> 30;
    t = 64'd1073741824;
    for (int i = 0; i < 6; i++) begin
      p = ((x2 * t) >> 30) / dv[i];
      t = (p > 64'd1073741824) ? 64'd0 : 64'd1073741824 - p;
    end
    e = mir ? 64'd1073741824 + t : 64'd1073741824 - t;
    e = (e + 64'd32768) >> 16;
    return e[15:0];
  endfunction

  function automatic logic [15:0] joint_clamp(input int j, input logic [15:0] v);
    logic [15:0] lo, hi;
    lo = {lim_lo[8*j +: 8], 8'h00};
    hi = {lim_hi[8*j +: 8], 8'h00};
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic model_reset();
    lim_lo = MinReset;
    lim_hi = MaxReset;
    home_deg = CenterReset;
    for (int j = 0; j < Joints; j++) begin
      cur_ang[j] = AngleReset;
      from_ang[j] = AngleReset;
      goal_ang[j] = AngleReset;
      queued_ang[j] = AngleReset;
    end
    ms_count = '0;
    move_ms = DurationReset;
    in_motion = 0;
    for (int i = 0; i < Curve; i++) ease_rom[i] = calc_ease(i);
  endtask

  task automatic model_move(input bit to_home, input logic [15:0] dur);
    logic [15:0] g;
    for (int j = 0; j < Joints; j++) begin
      g = to_home ? {home_deg[8*j +: 8], 8'h00} : queued_ang[j];
      from_ang[j] = cur_ang[j];
      goal_ang[j] = joint_clamp(j, g);
    end
    move_ms = (dur < MinDuration) ? MinDuration : dur;
    ms_count = '0;
    in_motion = 1;
  endtask

  // apply one command item to the model and queue the angles it produces
  task automatic predict_angles(input mode_e md, input logic [2:0] jn,
                                input logic [15:0] ang, input logic [15:0] dur,
                                input bit ok);
    int unsigned idx;
    longint unsigned ez, m;
    logic [15:0] v;
    angle_res_t r;
    case (md)
      MODE_LOAD: if (jn < Joints) queued_ang[jn] = ang;
      MODE_START: if (ok) model_move(0, dur);
      MODE_HOME: if (ok) model_move(1, HomeDuration);
      default: begin
        if (in_motion && ms_count != 16'hFFFF) ms_count++;
        if (ok && in_motion) begin
          if (ms_count >= move_ms) begin
            idx = Curve - 1;
            in_motion = 0;
          end else begin
            idx = ms_count * (Curve - 1) / move_ms;
          end
          ez = ease_rom[idx];
          for (int j = 0; j < Joints; j++) begin
            if (goal_ang[j] >= from_ang[j]) begin
              m = ((goal_ang[j] - from_ang[j]) * ez + 16384) >> 15;
              v = from_ang[j] + m[15:0];
            end else begin
              m = ((from_ang[j] - goal_ang[j]) * ez + 16384) >> 15;
              v = from_ang[j] - m[15:0];
            end
            v = joint_clamp(j, v);
            cur_ang[j] = v;
            r.joint_index = j[2:0];
            r.joint_angle = v;
            r.last_joint = (j == Joints - 1);
            expected_angles.push_back(r);
          end
        end
      end
    endcase
  endtask

  // send one item, with sender gaps between random bursts
  task automatic send_item(input mode_e md, input logic [2:0] jn,
                           input logic [15:0] ang, input logic [15:0] dur,
                           input bit ok);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        cmd_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= md;
    cmd_ch.joint <= jn;
    cmd_ch.angle <= ang;
    cmd_ch.duration_ms <= dur;
    cmd_ch.motion_allowed <= ok;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    predict_angles(md, jn, ang, dur, ok);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (expected_angles.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MIN: lim_lo = val;
      CFG_MAX: lim_hi = val;
      default: home_deg = val;
    endcase
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd46080;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 46080));
    endcase
  endfunction

  // directed: extremes of fields, ignored items, short and home moves
  task automatic test_directed();
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0, 1);
    send_item(MODE_LOAD, 3'd7, 16'hFFFF, 16'd0, 1);
    send_item(MODE_LOAD, 3'd0, 16'd0, 16'd0, 1);
    send_item(MODE_LOAD, 3'd5, 16'd46080, 16'd0, 0);
    send_item(MODE_LOAD, 3'd2, 16'hFFFF, 16'd0, 1);
    send_item(MODE_START, 3'd0, 16'd0, 16'd0, 0);
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0, 1);
    send_item(MODE_START, 3'd7, 16'hFFFF, 16'd0, 1);
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0, 0);
    for (int i = 0; i < 21; i++) send_item(MODE_TICK, 3'd0, 16'd0, 16'd0, 1);
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0, 1);
    send_item(MODE_HOME, 3'd0, 16'd0, 16'hFFFF, 1);
    send_item(MODE_TICK, 3'd0, 16'd0, 16'd0, 1);
    send_item(MODE_HOME, 3'd0, 16'd0, 16'd0, 0);
    wait_drained();
  endtask

  // well-formed moves with random content, plus noise
  task automatic test_random_moves(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        for (int j = 0; j < Joints; j++)
          if ($urandom_range(0, 3) != 0) begin
            send_item(MODE_LOAD, j[2:0], rand_angle(), 16'($urandom), 1'($urandom));
            sent++;
          end
        if ($urandom_range(0, 4) == 0)
          send_item(MODE_HOME, 3'($urandom), 16'($urandom), 16'($urandom), 1);
        else
          send_item(MODE_START, 3'($urandom), 16'($urandom),
                    16'($urandom_range(0, 30)), 1);
        sent++;
        repeat ($urandom_range(3, 12)) begin
          send_item(MODE_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                    $urandom_range(0, 5) != 0);
          sent++;
        end
      end else begin
        send_item(mode_e'($urandom_range(0, 3)), 3'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom));
        sent++;
      end
    end
    wait_drained();
  endtask

  // limits and home angles at several settings, extremes included
  task automatic test_config();
    write_cfg(CFG_MIN, 48'h0);
    write_cfg(CFG_MAX, 48'hFFFFFFFFFFFF);
    write_cfg(CFG_CENTER, 48'hFF00FF00FF00);
    test_random_moves(35);
    write_cfg(CFG_MIN, 48'({$urandom, $urandom}) & 48'h3C3C3C3C3C3C);
    write_cfg(CFG_MAX, 48'({$urandom, $urandom}) | 48'h808080808080);
    write_cfg(CFG_CENTER, 48'({$urandom, $urandom}));
    test_random_moves(35);
    write_cfg(CFG_MIN, 48'hFFFFFFFFFFFF);
    write_cfg(CFG_MAX, 48'h0);
    test_random_moves(15);
    write_cfg(CFG_MIN, MinReset);
    write_cfg(CFG_MAX, MaxReset);
    write_cfg(CFG_CENTER, CenterReset);
  endtask

  // long move interrupted by a restart, then a short move run to its end
  task automatic test_long_move();
    send_item(MODE_LOAD, 3'd1, 16'd46080, 16'd0, 1);
    send_item(MODE_START, 3'd0, 16'd0, 16'hFFFF, 1);
    repeat (10) send_item(MODE_TICK, 3'd0, 16'd0, 16'd0, 1);
    send_item(MODE_START, 3'd0, 16'd0, 16'd40, 1);
    repeat (45) send_item(MODE_TICK, 3'd0, 16'd0, 16'd0, 1);
    wait_drained();
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (!rst_ni) ang_ch.ready <= 1'b0;
    else ang_ch.ready <= ($urandom_range(0, 3) != 0) || ($time % 4000 < 800);
  end

  // result checker
  always @(posedge clk_i) begin
    angle_res_t exp_r;
    if (rst_ni && ang_ch.valid && ang_ch.ready) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result joint %0d angle %0d", $time,
                 ang_ch.joint_index, ang_ch.joint_angle);
        errors++;
      end else begin
        exp_r = expected_angles.pop_front();
        if (ang_ch.joint_index !== exp_r.joint_index ||
            ang_ch.joint_angle !== exp_r.joint_angle ||
            ang_ch.last_joint !== exp_r.last_joint) begin
          $display("%0t: mismatch expected j%0d a%0d l%0d actual j%0d a%0d l%0d",
                   $time, exp_r.joint_index, exp_r.joint_angle, exp_r.last_joint,
                   ang_ch.joint_index, ang_ch.joint_angle, ang_ch.last_joint);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (ang_ch.valid && ang_ch.ready) ||
        !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= WdLimit) begin
      $display("tb_cosine_eased_joint_trajectory failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MIN;
    cfg_data_i = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = MODE_TICK;
    cmd_ch.joint = '0;
    cmd_ch.angle = '0;
    cmd_ch.duration_ms = '0;
    cmd_ch.motion_allowed = 1'b0;
    model_reset();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_long_move();
    test_random_moves(70);
    test_config();
    while (expected_angles.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0 && expected_angles.size() == 0)
      $display("tb_cosine_eased_joint_trajectory passed");
    else
      $display("tb_cosine_eased_joint_trajectory failed");
    $finish;
  end

endmodule

`default_nettype wire
